/* rtl/psdl_pkg.sv */
package psdl_pkg;

	// Configuration register indexes
	localparam logic CFG_STANDARD   = 1'b0;
	localparam logic CFG_LINE_WIDTH = 1'b1;

	// Decoding standards
	localparam logic STD_PAL   = 1'b0;
	localparam logic STD_SECAM = 1'b1;

	// Field widths
	localparam int LUMA_W   = 11;
	localparam int CHROMA_W = 12;
	localparam int LW_W     = 9;
	localparam int ACC_W    = 26;
	localparam logic [LW_W-1:0] LINE_WIDTH_RST = 9'd160;

	// Matrix coefficients, 1.0 = 1024
	localparam logic signed [12:0] K_PAL_RV   = 13'sd1167;
	localparam logic signed [12:0] K_PAL_GU   = 13'sd404;
	localparam logic signed [12:0] K_PAL_GV   = 13'sd595;
	localparam logic signed [12:0] K_PAL_BU   = 13'sd2081;
	localparam logic signed [12:0] K_SECAM_RR = 13'sd539;
	localparam logic signed [12:0] K_SECAM_GB = 13'sd132;
	localparam logic signed [12:0] K_SECAM_GR = 13'sd274;
	localparam logic signed [12:0] K_SECAM_BB = 13'sd681;

	typedef logic signed [ACC_W-1:0] acc_t;

	// One pixel after the input register
	typedef struct packed {
		logic [LUMA_W-1:0]          luma;
		logic signed [CHROMA_W-1:0] chroma_first;
		logic signed [CHROMA_W-1:0] chroma_second;
		logic                       phase_inverted;
		logic                       odd_line;
		logic                       first_line;
	} pix_t;

	// Per channel accumulators, scale 2^21
	typedef struct packed {
		acc_t red;
		acc_t green;
		acc_t blue;
	} rgb_acc_t;

endpackage

/* rtl/psdl_line_ctrl.sv */
module psdl_line_ctrl
	import psdl_pkg::*;
#(
	parameter int MAX_LINE_WIDTH = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic                      frame_start,
	input  logic [2*CHROMA_W-1:0]     chroma_in,
	input  logic [LW_W-1:0]           line_width,
	output logic                      odd_line,
	output logic                      first_line,
	output logic [2*CHROMA_W-1:0]     prev_chroma
);

	localparam int AW = $clog2(MAX_LINE_WIDTH);
	localparam int CW = (AW + 1 > LW_W) ? AW + 1 : LW_W;

	logic [AW-1:0]           column_q;
	logic                    odd_q;
	logic                    first_q;
	logic [AW-1:0]           idx;
	logic [CW-1:0]           col_next;
	logic [CW-1:0]           lw_ext;
	logic [CW-1:0]           width_eff;
	logic [2*CHROMA_W-1:0]   store_q [MAX_LINE_WIDTH];

	// Frame start clears position before the pixel is used
	always_comb begin
		idx        = frame_start ? '0 : column_q;
		odd_line   = frame_start ? 1'b0 : odd_q;
		first_line = frame_start ? 1'b1 : first_q;
	end

	// Clamp line width to 1 .. MAX_LINE_WIDTH
	always_comb begin
		lw_ext = CW'(line_width);
		if (lw_ext == '0) begin
			width_eff = CW'(1);
		end else if (lw_ext > CW'(MAX_LINE_WIDTH)) begin
			width_eff = CW'(MAX_LINE_WIDTH);
		end else begin
			width_eff = lw_ext;
		end
		col_next = CW'(idx) + CW'(1);
	end

	// Advance column, wrap at line end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			odd_q    <= 1'b0;
			first_q  <= 1'b1;
		end else if (accept) begin
			if (col_next >= width_eff) begin
				column_q <= '0;
				odd_q    <= !odd_line;
				first_q  <= 1'b0;
			end else begin
				column_q <= col_next[AW-1:0];
				odd_q    <= odd_line;
				first_q  <= first_line;
			end
		end
	end

	// Line store: read the previous line's entry, replace it with this pixel
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_chroma   <= store_q[idx];
			store_q[idx]  <= chroma_in;
		end
	end

endmodule

/* rtl/psdl_matrix.sv */
module psdl_matrix
	import psdl_pkg::*;
(
	input  logic                  clk,
	input  logic                  en,
	input  logic                  standard,
	input  pix_t                  pix,
	input  logic [2*CHROMA_W-1:0] prev_chroma,
	output rgb_acc_t              acc_s2
);

	logic signed [CHROMA_W-1:0] p1;
	logic signed [CHROMA_W-1:0] p2;
	logic signed [CHROMA_W:0]   su;
	logic signed [CHROMA_W:0]   sv;
	logic signed [CHROMA_W:0]   db;
	logic signed [CHROMA_W:0]   dr;
	acc_t                       yy;
	rgb_acc_t                   acc;

	// Stored chroma counts as zero on the first line of a frame
	always_comb begin
		p1 = pix.first_line ? '0 : $signed(prev_chroma[CHROMA_W-1:0]);
		p2 = pix.first_line ? '0 : $signed(prev_chroma[2*CHROMA_W-1:CHROMA_W]);
	end

	// Doubled chroma: PAL sums or V difference if phase inverted, SECAM picks times two
	always_comb begin
		su = (CHROMA_W+1)'(pix.chroma_first) + (CHROMA_W+1)'(p1);
		if (pix.phase_inverted) begin
			sv = (CHROMA_W+1)'(pix.chroma_second) - (CHROMA_W+1)'(p2);
		end else begin
			sv = (CHROMA_W+1)'(pix.chroma_second) + (CHROMA_W+1)'(p2);
		end
		db = pix.odd_line ? {p1, 1'b0} : {pix.chroma_first, 1'b0};
		dr = pix.odd_line ? {pix.chroma_second, 1'b0} : {p2, 1'b0};
	end

	// Color matrix, scale 2^21
	always_comb begin
		yy = $signed(ACC_W'({pix.luma, 11'b0}));
		if (standard == STD_PAL) begin
			acc.red   = yy + acc_t'(sv) * acc_t'(K_PAL_RV);
			acc.green = yy - acc_t'(su) * acc_t'(K_PAL_GU) - acc_t'(sv) * acc_t'(K_PAL_GV);
			acc.blue  = yy + acc_t'(su) * acc_t'(K_PAL_BU);
		end else begin
			acc.red   = yy - acc_t'(dr) * acc_t'(K_SECAM_RR);
			acc.green = yy - acc_t'(db) * acc_t'(K_SECAM_GB) + acc_t'(dr) * acc_t'(K_SECAM_GR);
			acc.blue  = yy + acc_t'(db) * acc_t'(K_SECAM_BB);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s2 <= acc;
		end
	end

endmodule

/* rtl/psdl_rgb_out.sv */
module psdl_rgb_out
	import psdl_pkg::*;
(
	input  logic     clk,
	input  logic     en,
	input  rgb_acc_t acc_s2,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);

	localparam int MW = ACC_W + 8;

	// Scale by 255, drop 21 fraction bits, clamp to 0 .. 255
	function automatic logic [7:0] to_byte(input acc_t acc);
		logic signed [MW-1:0] m;
		m = (MW'(acc) <<< 8) - MW'(acc);
		if (acc < 0) begin
			to_byte = 8'd0;
		end else if (|m[MW-1:29]) begin
			to_byte = 8'd255;
		end else begin
			to_byte = m[28:21];
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			red   <= to_byte(acc_s2.red);
			green <= to_byte(acc_s2.green);
			blue  <= to_byte(acc_s2.blue);
		end
	end

endmodule

/* rtl/pal_secam_delay_line_decoder.sv */
// Channel   Dir  Payload
// s_*       in   tdata: luma, chroma_first, chroma_second; tuser: frame_start, phase_inverted
// m_*       out  tdata: red, green, blue
// cfg_*     in   cfg_index selects standard or line_width, cfg_data carries the value
//
// One pixel per clock while the output is not stalled; each request passes the
// input register with line store read, the matrix register and the output register.
// Reset clears line position, standard (PAL) and line width (160); the line
// store holds no reset value. A stalled output freezes the whole pipeline,
// and s_tready drops only while a result is waiting and m_tready is low.
module pal_secam_delay_line_decoder
	import psdl_pkg::*;
#(
	parameter int MAX_LINE_WIDTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // luma[10:0], chroma_first[22:11], chroma_second[34:23], zero
	input  logic [1:0]  s_tuser,   // frame_start[0], phase_inverted[1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // red[7:0], green[15:8], blue[23:16]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data
);

	logic                  en;
	logic                  accept;
	logic                  v_s1;
	logic                  v_s2;
	logic                  v_s3;
	logic                  standard_q;
	logic [LW_W-1:0]       line_width_q;
	logic                  odd_line;
	logic                  first_line;
	logic [2*CHROMA_W-1:0] prev_chroma;
	pix_t                  pix_s1;
	rgb_acc_t              acc_s2;
	logic [7:0]            red;
	logic [7:0]            green;
	logic [7:0]            blue;

	// Pipeline advances unless a result is held
	assign en       = !v_s3 || m_tready;
	assign s_tready = en;
	assign accept   = s_tvalid && en;
	assign m_tvalid = v_s3;
	assign m_tdata  = {blue, green, red};

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			standard_q   <= STD_PAL;
			line_width_q <= LINE_WIDTH_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_STANDARD:   standard_q   <= cfg_data[0];
				CFG_LINE_WIDTH: line_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1.luma           <= s_tdata[10:0];
			pix_s1.chroma_first   <= s_tdata[22:11];
			pix_s1.chroma_second  <= s_tdata[34:23];
			pix_s1.phase_inverted <= s_tuser[1];
			pix_s1.odd_line       <= odd_line;
			pix_s1.first_line     <= first_line;
		end
	end

	psdl_line_ctrl #(
		.MAX_LINE_WIDTH(MAX_LINE_WIDTH)
	) u_line_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.frame_start (s_tuser[0]),
		.chroma_in   (s_tdata[34:11]),
		.line_width  (line_width_q),
		.odd_line    (odd_line),
		.first_line  (first_line),
		.prev_chroma (prev_chroma)
	);

	psdl_matrix u_matrix (
		.clk         (clk),
		.en          (en),
		.standard    (standard_q),
		.pix         (pix_s1),
		.prev_chroma (prev_chroma),
		.acc_s2      (acc_s2)
	);

	psdl_rgb_out u_rgb_out (
		.clk    (clk),
		.en     (en),
		.acc_s2 (acc_s2),
		.red    (red),
		.green  (green),
		.blue   (blue)
	);

endmodule
